### design/i2cbs_pkg.sv
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned CmdW        = 3;
  localparam int unsigned PhaseW      = 5;

  // phase indexes inside a command
  localparam logic [PhaseW-1:0] WrBitPhases = PhaseW'(3 * BitsPerByte);    // 24
  localparam logic [PhaseW-1:0] WrAckLow    = WrBitPhases;
  localparam logic [PhaseW-1:0] WrAckHigh   = PhaseW'(3 * BitsPerByte + 1);
  localparam logic [PhaseW-1:0] WrRelease   = PhaseW'(3 * BitsPerByte + 2);
  localparam logic [PhaseW-1:0] RdBitPhases = PhaseW'(2 * BitsPerByte);    // 16
  localparam logic [PhaseW-1:0] RdTurn      = RdBitPhases;
  localparam logic [PhaseW-1:0] RdAckLow    = PhaseW'(2 * BitsPerByte + 1);
  localparam logic [PhaseW-1:0] RdAckData   = PhaseW'(2 * BitsPerByte + 2);
  localparam logic [PhaseW-1:0] RdAckHigh   = PhaseW'(2 * BitsPerByte + 3);
  localparam logic [PhaseW-1:0] RdAckEnd    = PhaseW'(2 * BitsPerByte + 4);
  localparam logic [PhaseW-1:0] MaxPhase    = WrRelease;

  typedef enum logic [CmdW-1:0] {
    CMD_START     = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_READ_ACK  = 3'd2,
    CMD_READ_NACK = 3'd3,
    CMD_STOP      = 3'd4
  } cmd_e;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_RUN
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;            // capture bytes of a new request
    logic step;            // emit one phase
    logic scl_set;
    logic scl_val;
    logic sda_set;
    logic sda_from_shift;  // SDA takes shifter MSB
    logic sda_val;
    logic en_set;
    logic en_val;
    logic hold;
    logic last;
    logic shift;
    logic rd_out;          // present read byte on this phase
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

### design/i2cbs_dp.sv
// ----------------------------------------------------------------------------
// i2cbs_dp
// Pin latches, byte shifter, read byte holder and phase output register.
// ----------------------------------------------------------------------------
module i2cbs_dp import i2cbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  input  logic [BitsPerByte-1:0] wr_byte_i,
  input  logic [BitsPerByte-1:0] rd_byte_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic                   out_scl_o,
  output logic                   out_sda_o,
  output logic                   out_drive_o,
  output logic                   out_hold_o,
  output logic [BitsPerByte-1:0] out_read_o,
  output logic                   out_last_o
);

  logic scl_q, scl_d, sda_q, sda_d, en_q, en_d;
  logic [BitsPerByte-1:0] shift_q, shift_d, rbyte_q, rbyte_d;
  logic ov_q, ov_d;
  logic o_scl_q, o_sda_q, o_en_q, o_hold_q, o_last_q;
  logic [BitsPerByte-1:0] o_read_q;

  assign stat_o.out_free = !ov_q || out_ready_i;

  always_comb begin
    scl_d   = scl_q;
    sda_d   = sda_q;
    en_d    = en_q;
    shift_d = shift_q;
    rbyte_d = rbyte_q;
    if (cmd_i.load) begin
      shift_d = wr_byte_i;
      rbyte_d = rd_byte_i;
    end
    if (cmd_i.step) begin
      if (cmd_i.scl_set) scl_d = cmd_i.scl_val;
      if (cmd_i.sda_set) sda_d = cmd_i.sda_from_shift ? shift_q[BitsPerByte-1] : cmd_i.sda_val;
      if (cmd_i.en_set)  en_d  = cmd_i.en_val;
      if (cmd_i.shift)   shift_d = {shift_q[BitsPerByte-2:0], 1'b0};
    end
    ov_d = cmd_i.step ? 1'b1 : (ov_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_q   <= 1'b0;
      sda_q   <= 1'b1;
      en_q    <= 1'b1;
      shift_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      en_q    <= en_d;
      shift_q <= shift_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rbyte_q <= rbyte_d;
    if (cmd_i.step) begin
      o_scl_q  <= scl_d;
      o_sda_q  <= sda_d;
      o_en_q   <= en_d;
      o_hold_q <= cmd_i.hold;
      o_last_q <= cmd_i.last;
      o_read_q <= cmd_i.rd_out ? rbyte_q : '0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_scl_o   = o_scl_q;
  assign out_sda_o   = o_sda_q;
  assign out_drive_o = o_en_q;
  assign out_hold_o  = o_hold_q;
  assign out_read_o  = o_read_q;
  assign out_last_o  = o_last_q;

endmodule

### design/i2cbs_ctrl.sv
// ----------------------------------------------------------------------------
// i2cbs_ctrl
// Command sequencer: walks the phase list of each request, drives datapath.
// ----------------------------------------------------------------------------
module i2cbs_ctrl import i2cbs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [CmdW-1:0] in_cmd_i,
  output dp_cmd_t         dp_cmd_o,
  input  dp_stat_t        dp_stat_i
);

  ctrl_state_e       state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [PhaseW-1:0] ph_q, ph_d;
  logic [1:0]        sub_q, sub_d;
  logic              accept;
  dp_cmd_t           c;

  assign in_ready_o = (state_q == CTRL_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    ph_d    = ph_q;
    sub_d   = sub_q;
    c       = '0;

    case (state_q)
      CTRL_IDLE: begin
        if (accept && in_cmd_i <= CMD_STOP) begin
          c.load  = 1'b1;
          cmd_d   = cmd_e'(in_cmd_i);
          ph_d    = '0;
          sub_d   = '0;
          state_d = CTRL_RUN;
        end
      end
      CTRL_RUN: begin
        if (dp_stat_i.out_free) begin
          c.step = 1'b1;
          case (cmd_q)
            CMD_START: begin
              case (ph_q)
                5'd0: begin
                  c.en_set = 1'b1; c.en_val = 1'b1;
                  c.sda_set = 1'b1; c.sda_val = 1'b1;
                  c.scl_set = 1'b1; c.scl_val = 1'b1;
                end
                5'd1: begin c.sda_set = 1'b1; c.sda_val = 1'b0; end
                default: begin c.scl_set = 1'b1; c.scl_val = 1'b0; c.last = 1'b1; end
              endcase
            end
            CMD_STOP: begin
              case (ph_q)
                5'd0: begin c.scl_set = 1'b1; c.scl_val = 1'b0; end
                5'd1: begin c.sda_set = 1'b1; c.sda_val = 1'b0; end
                5'd2: begin c.scl_set = 1'b1; c.scl_val = 1'b1; c.hold = 1'b1; end
                default: begin c.sda_set = 1'b1; c.sda_val = 1'b1; c.last = 1'b1; end
              endcase
            end
            CMD_WRITE: begin
              if (ph_q < WrBitPhases) begin
                case (sub_q)
                  2'd0: begin c.scl_set = 1'b1; c.scl_val = 1'b0; end
                  2'd1: begin c.sda_set = 1'b1; c.sda_from_shift = 1'b1; end
                  default: begin
                    c.scl_set = 1'b1; c.scl_val = 1'b1; c.hold = 1'b1; c.shift = 1'b1;
                  end
                endcase
              end else if (ph_q == WrAckLow) begin
                c.scl_set = 1'b1; c.scl_val = 1'b0;
                c.en_set = 1'b1; c.en_val = 1'b0; c.hold = 1'b1;
              end else if (ph_q == WrAckHigh) begin
                // acknowledge clock, slave level not used
                c.scl_set = 1'b1; c.scl_val = 1'b1; c.hold = 1'b1;
              end else begin
                c.scl_set = 1'b1; c.scl_val = 1'b0;
                c.en_set = 1'b1; c.en_val = 1'b1;
                c.sda_set = 1'b1; c.sda_val = 1'b1;
                c.hold = 1'b1; c.last = 1'b1;
              end
            end
            default: begin  // both read flavors
              if (ph_q < RdBitPhases) begin
                c.en_set = 1'b1; c.en_val = 1'b0;
                c.scl_set = 1'b1; c.scl_val = ph_q[0]; c.hold = ph_q[0];
              end else if (ph_q == RdTurn) begin
                c.scl_set = 1'b1; c.scl_val = 1'b0;
              end else if (ph_q == RdAckLow) begin
                c.en_set = 1'b1; c.en_val = 1'b1;
                c.scl_set = 1'b1; c.scl_val = 1'b0;
              end else if (ph_q == RdAckData) begin
                c.sda_set = 1'b1; c.sda_val = (cmd_q != CMD_READ_ACK);
              end else if (ph_q == RdAckHigh) begin
                c.scl_set = 1'b1; c.scl_val = 1'b1;
                if (cmd_q != CMD_READ_ACK) begin
                  c.hold = 1'b1; c.last = 1'b1; c.rd_out = 1'b1;
                end
              end else begin
                c.scl_set = 1'b1; c.scl_val = 1'b0;
                c.last = 1'b1; c.rd_out = 1'b1;
              end
            end
          endcase

          if (c.last) begin
            state_d = CTRL_IDLE;
          end else begin
            ph_d  = ph_q + 1'b1;
            sub_d = (sub_q == 2'd2) ? 2'd0 : sub_q + 1'b1;
          end
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  assign dp_cmd_o = c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
      cmd_q   <= CMD_START;
      ph_q    <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      ph_q    <= ph_d;
      sub_q   <= sub_d;
    end
  end

  a_step_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c.step |-> state_q == CTRL_RUN) else $error("phase emitted while idle");
  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CTRL_RUN |-> ph_q <= MaxPhase) else $error("phase index overrun");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c.last |=> state_q == CTRL_IDLE) else $error("sequencer kept running after last");
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c.load |=> state_q == CTRL_RUN && ph_q == '0) else $error("bad command start");
  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q != 2'd3) else $error("bit sub-phase out of range");

endmodule

### design/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Byte-level I2C master turning start/write/read/stop requests into pin phases.
// ----------------------------------------------------------------------------
// Each accepted request is expanded into a list of pin phases, one phase per
// clock when the output side is ready: start gives 3 phases, write 27,
// read with ACK 21, read with NACK 20 and stop 4. The next request is taken
// only after the controller has emitted the last phase of the request before
// and gone back to idle. Each phase carries the SCL level, the SDA output
// latch, the SDA drive enable and a short/long hold flag; the final phase
// of a request has tlast set, and on a read it also carries the assembled
// byte (zero on all other phases). The slave's eight read bits arrive with
// the request, MSB first in bus_byte. The ACK clock after a write is
// generated but the level is not examined. Command codes 5..7 are consumed
// with no phases. The last phase may still sit in the output register while
// the next request is accepted.
module i2c_master_bit_sequencer import i2cbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] bus_byte
  input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
  // phase channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] scl_level, [1] sda_level,
                                      // [2] sda_drive, [3] hold_long,
                                      // [11:4] read_value, [15:12] zero
  output logic        m_axis_tlast    // last_phase
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  logic                   o_scl, o_sda, o_drive, o_hold;
  logic [BitsPerByte-1:0] o_read;

  // sequencer: phase index per request
  i2cbs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_cmd_i  (s_axis_tuser),
    .dp_cmd_o  (dp_cmd),
    .dp_stat_i (dp_stat)
  );

  // pin latches, shifter and phase output register
  i2cbs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .wr_byte_i  (s_axis_tdata[7:0]),
    .rd_byte_i  (s_axis_tdata[15:8]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_scl_o  (o_scl),
    .out_sda_o  (o_sda),
    .out_drive_o(o_drive),
    .out_hold_o (o_hold),
    .out_read_o (o_read),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, o_read, o_hold, o_drive, o_sda, o_scl};

endmodule

### tb/sv/i2cbs_phase_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbs_phase_check_pkg
// Pin phase prediction and checking for the I2C master bit sequencer bench.
// ----------------------------------------------------------------------------
// Every accepted request is expanded here into the pin phases it must
// produce. The bench's own copy of the pin latches and the byte shifter
// follows each command. Every phase that leaves the block is compared with
// the oldest prediction.
// ----------------------------------------------------------------------------
package i2cbs_phase_check_pkg;

  import i2cbs_pkg::*;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drive;
    logic       hold_long;
    logic [7:0] rd_byte;
    logic       is_last;
  } pin_phase_t;

  class pin_phase_checker;

    pin_phase_t due_phases[$];
    int         failures;

    // pin latches and shifter as they stand after the latest request
    logic       scl_q;
    logic       sda_q;
    logic       drive_q;
    logic [7:0] shifter_q;

    function new();
      failures  = 0;
      scl_q     = 1'b0;
      sda_q     = 1'b1;
      drive_q   = 1'b1;
      shifter_q = 8'h00;
    endfunction

    function int pending();
      return due_phases.size();
    endfunction

    function void emit(logic hold);
      pin_phase_t p;
      p.scl       = scl_q;
      p.sda       = sda_q;
      p.drive     = drive_q;
      p.hold_long = hold;
      p.rd_byte   = 8'h00;
      p.is_last   = 1'b0;
      due_phases.push_back(p);
    endfunction

    // Expand one accepted request into its pin phases.
    function void note_request(logic [2:0] cmd, logic [7:0] tx_byte, logic [7:0] rx_byte);
      int tail;
      tail = 0;
      case (cmd)
        CMD_START: begin
          drive_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
          emit(1'b0);
          sda_q = 1'b0;
          emit(1'b0);
          scl_q = 1'b0;
          emit(1'b0);
        end
        CMD_STOP: begin
          // drive enable is taken as it stands
          scl_q = 1'b0;
          emit(1'b0);
          sda_q = 1'b0;
          emit(1'b0);
          scl_q = 1'b1;
          emit(1'b1);
          sda_q = 1'b1;
          emit(1'b0);
        end
        CMD_WRITE: begin
          shifter_q = tx_byte;
          for (int i = 0; i < BitsPerByte; i++) begin
            scl_q = 1'b0;
            emit(1'b0);
            sda_q = shifter_q[7];
            emit(1'b0);
            scl_q = 1'b1;
            emit(1'b1);
            shifter_q = {shifter_q[6:0], 1'b0};
          end
          // ack clock with SDA released, level not looked at
          scl_q = 1'b0; drive_q = 1'b0;
          emit(1'b1);
          scl_q = 1'b1;
          emit(1'b1);
          scl_q = 1'b0; drive_q = 1'b1; sda_q = 1'b1;
          emit(1'b1);
        end
        CMD_READ_ACK, CMD_READ_NACK: begin
          shifter_q = 8'h00;
          scl_q = 1'b0; drive_q = 1'b0;
          for (int i = 0; i < BitsPerByte; i++) begin
            scl_q = 1'b0;
            emit(1'b0);
            scl_q = 1'b1;
            emit(1'b1);
            shifter_q = {shifter_q[6:0], rx_byte[7 - i]};
          end
          scl_q = 1'b0;
          emit(1'b0);
          drive_q = 1'b1;
          if (cmd == CMD_READ_ACK) begin
            scl_q = 1'b0;
            emit(1'b0);
            sda_q = 1'b0;
            emit(1'b0);
            scl_q = 1'b1;
            emit(1'b0);
            scl_q = 1'b0;
            emit(1'b0);
          end else begin
            scl_q = 1'b0;
            emit(1'b0);
            sda_q = 1'b1;
            emit(1'b0);
            scl_q = 1'b1;
            emit(1'b1);
          end
        end
        default: begin
          // undefined codes are swallowed without phases
          return;
        end
      endcase
      tail = due_phases.size() - 1;
      due_phases[tail].is_last = 1'b1;
      if (cmd == CMD_READ_ACK || cmd == CMD_READ_NACK) begin
        due_phases[tail].rd_byte = shifter_q;
      end
    endfunction

    function void check_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
        failures++;
      end
    endfunction

    // Compare one phase taken from the block with the oldest prediction.
    function void check_phase(logic [15:0] data, logic last);
      pin_phase_t p;
      if (due_phases.size() == 0) begin
        $error("phase 0x%04h (tlast %0b) arrived with none pending", data, last);
        failures++;
        return;
      end
      p = due_phases.pop_front();
      check_field("scl_level", int'(p.scl), int'(data[0]));
      check_field("sda_level", int'(p.sda), int'(data[1]));
      check_field("sda_drive", int'(p.drive), int'(data[2]));
      check_field("hold_long", int'(p.hold_long), int'(data[3]));
      check_field("read_value", int'(p.rd_byte), int'(data[11:4]));
      check_field("pad", 0, int'(data[15:12]));
      check_field("last_phase", int'(p.is_last), int'(last));
    endfunction

  endclass

endpackage

### tb/sv/i2c_master_bit_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_tb
// Self-checking bench for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
// A directed list covers every command, the byte extremes, undefined codes
// and out-of-order use. Random I2C transfers follow (start, address, data
// bytes, reads ending in NACK, repeated starts, stop), mixed with noise and
// broken transfers. Both stream sides idle at random; every phase is
// checked against the predicted list.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_tb;

  import i2cbs_pkg::*;
  import i2cbs_phase_check_pkg::*;

  localparam int unsigned RandomItems = 370;
  localparam int unsigned TailCycles  = 40;       // above the longest command
  localparam int unsigned CycleLimit  = 500_000;

  // codes the block swallows without phases
  localparam logic [2:0] CmdRsvdFirst = 3'd5;
  localparam logic [2:0] CmdRsvdLast  = 3'd7;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [7:0] data_byte, [15:8] bus_byte
  logic [2:0]  s_axis_tuser  = '0;   // [2:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [0] scl, [1] sda, [2] drive, [3] hold,
                                     // [11:4] read_value, [15:12] zero
  logic        m_axis_tlast;

  pin_phase_checker phases = new();

  int unsigned cycle_count = 0;
  int unsigned n_requests  = 0;      // defined commands accepted so far
  bit          calm        = 1'b0;   // both sides run without idling

  i2c_master_bit_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("i2c_master_bit_sequencer_tb failed");
      $finish;
    end
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Issue one request. valid stays high into the next request when no gap
  // is drawn, so it is never dropped and raised in the same step.
  task automatic send_request(input logic [2:0] cmd, input logic [7:0] tx_byte,
                              input logic [7:0] rx_byte);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {rx_byte, tx_byte};
    do @(posedge clk_i); while (!s_axis_tready);
    phases.note_request(cmd, tx_byte, rx_byte);
    if (cmd <= CMD_STOP) n_requests++;
  endtask

  // Hold off the request side until every predicted phase is out.
  task automatic drain_phases(input int unsigned tail);
    s_axis_tvalid <= 1'b0;
    while (phases.pending() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // Phase sink: draws a stall before each phase, checks what it takes.
  initial begin : phase_sink
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      phases.check_phase(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin : stimulus
    logic [7:0]  addr;
    int          nbytes;
    int          nnoise;
    int unsigned rand_target;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // out of order straight from reset: stop, then a read with no start
    send_request(CMD_STOP, 8'hFF, 8'h00);
    send_request(CMD_READ_ACK, 8'h00, 8'hFF);
    send_request(CMD_START, 8'h00, 8'h00);
    send_request(CMD_WRITE, 8'h00, 8'hFF);
    send_request(CMD_WRITE, 8'hFF, 8'h00);
    send_request(CMD_WRITE, 8'hA5, 8'h5A);
    send_request(CMD_WRITE, 8'h5A, 8'hA5);
    send_request(CMD_READ_ACK, 8'hFF, 8'h00);
    send_request(CMD_READ_ACK, 8'h00, 8'hFF);
    send_request(CMD_READ_NACK, 8'h5A, 8'hA5);
    send_request(CMD_READ_NACK, 8'hA5, 8'h5A);
    send_request(CMD_STOP, 8'h00, 8'h00);
    // undefined codes in between: no phases, no state change
    for (int c = CmdRsvdFirst; c <= CmdRsvdLast; c++) begin
      send_request(c[2:0], 8'hFF, 8'hFF);
    end
    send_request(CMD_START, 8'hFF, 8'hFF);
    send_request(CMD_START, 8'h00, 8'h00);       // start twice in a row
    send_request(CMD_WRITE, 8'h80, 8'h01);
    send_request(CMD_READ_NACK, 8'h01, 8'h80);
    send_request(CMD_STOP, 8'hFF, 8'hFF);
    send_request(CMD_STOP, 8'h00, 8'h00);        // stop twice in a row
    drain_phases(TailCycles);

    // --- random part ---
    rand_target = n_requests + RandomItems;
    while (n_requests < rand_target) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 80) begin
        // well-formed transfer with random content
        send_request(CMD_START, rnd_byte(), rnd_byte());
        addr = rnd_byte();
        send_request(CMD_WRITE, addr, rnd_byte());
        if (!addr[0] && $urandom_range(0, 3) == 0) begin
          // register write then repeated start into a read
          send_request(CMD_WRITE, rnd_byte(), rnd_byte());
          send_request(CMD_START, rnd_byte(), rnd_byte());
          addr[0] = 1'b1;
          send_request(CMD_WRITE, addr, rnd_byte());
        end
        nbytes = $urandom_range(1, 6);
        for (int k = 0; k < nbytes; k++) begin
          if (addr[0]) begin
            send_request((k == nbytes - 1) ? CMD_READ_NACK : CMD_READ_ACK,
                         rnd_byte(), rnd_byte());
          end else begin
            send_request(CMD_WRITE, rnd_byte(), rnd_byte());
          end
        end
        // now and then the stop is missing
        if ($urandom_range(0, 9) != 0) begin
          send_request(CMD_STOP, rnd_byte(), rnd_byte());
        end
      end else begin
        // noise: any code, defined or not
        nnoise = $urandom_range(1, 4);
        for (int k = 0; k < nnoise; k++) begin
          send_request(3'($urandom_range(0, 7)), rnd_byte(), rnd_byte());
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        drain_phases(2);
      end
    end
    calm = 1'b0;

    drain_phases(TailCycles);
    if (phases.failures == 0) begin
      $display("i2c_master_bit_sequencer_tb passed");
    end else begin
      $display("i2c_master_bit_sequencer_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/i2cbs_pkg.sv
design/i2cbs_dp.sv
design/i2cbs_ctrl.sv
design/i2c_master_bit_sequencer.sv
tb/sv/i2cbs_phase_check_pkg.sv
tb/sv/i2c_master_bit_sequencer_tb.sv
